/* rtl/jafl_pkg.sv */
// ----------------------------------------------------------------------------
// jafl_pkg: shared types and constants for the joint angle fusion low-pass.
// Holds the frame and result payloads, the configuration set, the lane
// control group and the saturation helper used by the angle datapaths.
// ----------------------------------------------------------------------------
package jafl_pkg;

  localparam int JOINT_COUNT = 6;

  typedef logic signed [15:0] angle_t;
  typedef logic [16:0] gain_t;
  typedef angle_t [JOINT_COUNT-1:0] joint_vec_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_GAIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_IK_WEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_HAND_WEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRIST_PITCH_MIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WRIST_PITCH_MAX = 3'd4;

  localparam gain_t LOWPASS_GAIN_RESET = 17'd16384;
  localparam gain_t ROLL_IK_WEIGHT_RESET = 17'd32768;
  localparam gain_t ROLL_HAND_WEIGHT_RESET = 17'd32768;
  localparam angle_t WRIST_PITCH_MIN_RESET = -16'sd11520;
  localparam angle_t WRIST_PITCH_MAX_RESET = 16'sd11520;
  localparam angle_t HELD_PITCH_RESET = 16'sd6400;

  localparam angle_t PITCH_FULL = 16'sd12800;
  localparam logic signed [32:0] PITCH_ROUND = 33'sd6400;
  localparam logic [21:0] PITCH_BIAS = 22'd1638400;
  localparam logic [22:0] RECIP_MULT = 23'd5368710;
  localparam logic signed [18:0] QUOT_BIAS = 19'sd65536;
  localparam logic signed [34:0] ROUND_HALF = 35'sd32768;

  typedef struct packed {
    logic [31:0] frame_time;
    angle_t      ik_base;
    angle_t      ik_shoulder;
    angle_t      ik_upper_roll;
    angle_t      ik_elbow;
    logic        hand_present;
    angle_t      hand_upper_roll;
    angle_t      hand_fore_roll;
    angle_t      hand_pitch;
    logic        command_present;
    logic        command_record;
  } frame_t;

  typedef struct packed {
    logic [31:0] out_time;
    angle_t      joint_one;
    angle_t      joint_two;
    angle_t      joint_three;
    angle_t      joint_four;
    angle_t      joint_five;
    angle_t      joint_six;
    logic        record_tap;
    logic        record_done;
  } result_t;

  typedef struct packed {
    gain_t  lowpass_gain;
    gain_t  roll_ik_weight;
    gain_t  roll_hand_weight;
    angle_t wrist_pitch_min;
    angle_t wrist_pitch_max;
  } cfg_t;

  typedef struct packed {
    angle_t upper_roll;
    angle_t fore_roll;
    angle_t pitch;
  } hold_t;

  typedef struct packed {
    logic mult;
    logic update;
    logic seeded;
  } lane_ctrl_t;

  function automatic angle_t sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

/* rtl/jafl_raw.sv */
// ----------------------------------------------------------------------------
// jafl_raw: raw joint angle builder.
// Forms the six unfiltered joint angles of a frame in a four-stage pipeline:
// the J3 blend of IK and hand roll, the negated hand roll, and the wrist
// pitch mapping, whose division by 12800 is a shift and a reciprocal multiply.
// ----------------------------------------------------------------------------
module jafl_raw import jafl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  frame_t     frame,
  input  hold_t      held,
  input  cfg_t       cfg,
  output joint_vec_t raw,
  output logic       done
);

  logic [3:0]         stage_valid;
  logic [13:0]        pitch_clamped;
  logic signed [16:0] span;
  logic signed [33:0] prod_ik;
  logic signed [33:0] prod_hand;
  logic signed [31:0] prod_pitch;
  logic signed [34:0] blend_sum;
  logic signed [32:0] pitch_num;
  logic [21:0]        pitch_offset_next;
  logic [21:0]        pitch_offset;
  logic [44:0]        quot_prod;
  logic signed [18:0] pitch_sum;
  logic signed [19:0] fore_neg;
  angle_t             joint_three;
  angle_t             joint_six;

  always_comb begin
    if (held.pitch < 16'sd0) begin
      pitch_clamped = '0;
    end else if (held.pitch > PITCH_FULL) begin
      pitch_clamped = PITCH_FULL[13:0];
    end else begin
      pitch_clamped = held.pitch[13:0];
    end
  end

  assign span = {cfg.wrist_pitch_max[15], cfg.wrist_pitch_max}
              - {cfg.wrist_pitch_min[15], cfg.wrist_pitch_min};

  assign blend_sum = {prod_ik[33], prod_ik} + {prod_hand[33], prod_hand} + ROUND_HALF;
  assign pitch_num = {prod_pitch[31], prod_pitch} + PITCH_ROUND;
  assign pitch_offset_next = pitch_num[30:9] + PITCH_BIAS;
  assign pitch_sum = {{3{cfg.wrist_pitch_min[15]}}, cfg.wrist_pitch_min}
                   + $signed({1'b0, quot_prod[44:27]}) - QUOT_BIAS;
  assign fore_neg = 20'sd0 - {{4{held.fore_roll[15]}}, held.fore_roll};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_ik <= $signed({1'b0, cfg.roll_ik_weight}) * frame.ik_upper_roll;
      prod_hand <= $signed({1'b0, cfg.roll_hand_weight}) * held.upper_roll;
      prod_pitch <= $signed({1'b0, pitch_clamped}) * span;
    end
    if (stage_valid[0]) begin
      joint_three <= sat16({blend_sum[34], blend_sum[34:16]});
      pitch_offset <= pitch_offset_next;
    end
    if (stage_valid[1]) begin
      quot_prod <= pitch_offset * RECIP_MULT;
    end
    if (stage_valid[2]) begin
      joint_six <= sat16({pitch_sum[18], pitch_sum});
    end
  end

  assign raw[0] = frame.ik_base;
  assign raw[1] = frame.ik_shoulder;
  assign raw[2] = joint_three;
  assign raw[3] = frame.ik_elbow;
  assign raw[4] = sat16(fore_neg);
  assign raw[5] = joint_six;
  assign done = stage_valid[3];

endmodule

/* rtl/jafl_lane.sv */
// ----------------------------------------------------------------------------
// jafl_lane: one low-pass filter lane.
// Holds one filtered joint angle; once seeded, it moves toward the new sample
// by the gain (registered multiply, rounded saturating add); else takes it.
// ----------------------------------------------------------------------------
module jafl_lane import jafl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  angle_t     sample,
  input  gain_t      gain,
  input  lane_ctrl_t ctrl,
  output angle_t     value
);

  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] prod_round;
  logic signed [19:0] sum;

  assign diff = {sample[15], sample} - {value[15], value};
  assign prod_round = prod + ROUND_HALF;
  assign sum = {{4{value[15]}}, value} + {prod_round[34], prod_round[34:16]};

  always_ff @(posedge clk) begin
    if (ctrl.mult) begin
      prod <= $signed({1'b0, gain}) * diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.update) begin
      value <= ctrl.seeded ? sat16(sum) : sample;
    end
  end

endmodule

/* rtl/joint_angle_fusion_lowpass_unit.sv */
// ----------------------------------------------------------------------------
// joint_angle_fusion_lowpass_unit: joint angle fusion with low-pass smoothing.
// Each frame is captured, then starts the raw angle pipeline, waits for it to
// finish, passes through the six parallel filter lanes (multiply, then
// update) and is loaded into the result register; only then is the next
// frame taken. A waiting result does not block the next frame; a result that
// is still not taken when the following one is done holds the block in its
// final step. The first frame after reset seeds the filters.
// ----------------------------------------------------------------------------
module joint_angle_fusion_lowpass_unit import jafl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  output logic                   frame_ready,
  input  frame_t                 frame,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RAW,
    ST_MULT,
    ST_UPDATE,
    ST_SEND
  } state_t;

  state_t     state;
  logic       accept;
  logic       send_now;
  frame_t     frame_q;
  cfg_t       cfg;
  hold_t      held;
  logic       recording;
  logic       recording_next;
  logic       record_tap;
  logic       record_done;
  logic       seeded;
  joint_vec_t raw;
  logic       raw_done;
  joint_vec_t filtered;
  lane_ctrl_t lane_ctrl;
  result_t    merged;

  assign frame_ready = (state == ST_IDLE);
  assign accept = frame_valid && frame_ready;
  assign send_now = (state == ST_SEND) && (!result_valid || result_ready);
  assign recording_next = frame.command_present ? frame.command_record : recording;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowpass_gain <= LOWPASS_GAIN_RESET;
      cfg.roll_ik_weight <= ROLL_IK_WEIGHT_RESET;
      cfg.roll_hand_weight <= ROLL_HAND_WEIGHT_RESET;
      cfg.wrist_pitch_min <= WRIST_PITCH_MIN_RESET;
      cfg.wrist_pitch_max <= WRIST_PITCH_MAX_RESET;
      held.upper_roll <= '0;
      held.fore_roll <= '0;
      held.pitch <= HELD_PITCH_RESET;
      recording <= 1'b0;
      seeded <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LOWPASS_GAIN: cfg.lowpass_gain <= cfg_data;
          REG_ROLL_IK_WEIGHT: cfg.roll_ik_weight <= cfg_data;
          REG_ROLL_HAND_WEIGHT: cfg.roll_hand_weight <= cfg_data;
          REG_WRIST_PITCH_MIN: cfg.wrist_pitch_min <= cfg_data[15:0];
          REG_WRIST_PITCH_MAX: cfg.wrist_pitch_max <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (frame.hand_present) begin
          held.upper_roll <= frame.hand_upper_roll;
          held.fore_roll <= frame.hand_fore_roll;
          held.pitch <= frame.hand_pitch;
        end
        recording <= recording_next;
      end
      if (state == ST_UPDATE) begin
        seeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_q <= frame;
      record_tap <= recording_next | recording;
      record_done <= recording & ~recording_next;
    end
  end

  jafl_raw u_raw (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_LOAD),
    .frame (frame_q),
    .held  (held),
    .cfg   (cfg),
    .raw   (raw),
    .done  (raw_done)
  );

  assign lane_ctrl.mult = (state == ST_MULT);
  assign lane_ctrl.update = (state == ST_UPDATE);
  assign lane_ctrl.seeded = seeded;

  for (genvar i = 0; i < JOINT_COUNT; i++) begin : g_lane
    jafl_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .sample (raw[i]),
      .gain   (cfg.lowpass_gain),
      .ctrl   (lane_ctrl),
      .value  (filtered[i])
    );
  end

  assign merged.out_time = frame_q.frame_time;
  assign merged.joint_one = filtered[0];
  assign merged.joint_two = filtered[1];
  assign merged.joint_three = filtered[2];
  assign merged.joint_four = filtered[3];
  assign merged.joint_five = filtered[4];
  assign merged.joint_six = filtered[5];
  assign merged.record_tap = record_tap;
  assign merged.record_done = record_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !send_now) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (frame_valid) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_RAW;
        ST_RAW: begin
          if (raw_done) begin
            state <= ST_MULT;
          end
        end
        ST_MULT: state <= ST_UPDATE;
        ST_UPDATE: state <= ST_SEND;
        ST_SEND: begin
          if (send_now) begin
            result_valid <= 1'b1;
            result <= merged;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* test/joint_angle_fusion_lowpass_unit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jafl_pose_checker: result checker for the joint angle fusion low-pass unit.
// Watches the frame, result and configuration ports. For every accepted frame
// it computes the expected filtered joint pose from its own copy of the
// registers and the fusion state, then compares every accepted result with
// the oldest pose that is still waiting.
// ----------------------------------------------------------------------------
module jafl_pose_checker import jafl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  input  logic                   frame_ready,
  input  frame_t                 frame,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  cfg_t    shadow_cfg;
  angle_t  filter_state [JOINT_COUNT];
  logic    filter_primed;
  hold_t   held_hand;
  logic    recording;
  result_t expected_poses [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic angle_t clamp_angle(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return angle_t'(v);
  endfunction

  function automatic result_t predict_pose(frame_t f);
    result_t r;
    angle_t  raw [JOINT_COUNT];
    longint  p;
    longint  span;
    longint  gain;
    logic    was;
    if (f.hand_present) begin
      held_hand.upper_roll = f.hand_upper_roll;
      held_hand.fore_roll = f.hand_fore_roll;
      held_hand.pitch = f.hand_pitch;
    end
    raw[0] = f.ik_base;
    raw[1] = f.ik_shoulder;
    raw[3] = f.ik_elbow;
    raw[2] = clamp_angle(round_q16(
        longint'(shadow_cfg.roll_ik_weight) * longint'($signed(f.ik_upper_roll))
        + longint'(shadow_cfg.roll_hand_weight) * longint'($signed(held_hand.upper_roll))));
    raw[4] = clamp_angle(-longint'($signed(held_hand.fore_roll)));
    p = longint'($signed(held_hand.pitch));
    if (p < 0) begin
      p = 0;
    end
    if (p > longint'(PITCH_FULL)) begin
      p = longint'(PITCH_FULL);
    end
    span = longint'($signed(shadow_cfg.wrist_pitch_max))
           - longint'($signed(shadow_cfg.wrist_pitch_min));
    raw[5] = clamp_angle(longint'($signed(shadow_cfg.wrist_pitch_min))
             + floor_div(p * span + longint'(PITCH_FULL) / 2, longint'(PITCH_FULL)));
    gain = longint'(shadow_cfg.lowpass_gain);
    for (int i = 0; i < JOINT_COUNT; i++) begin
      if (!filter_primed) begin
        filter_state[i] = raw[i];
      end else begin
        filter_state[i] = clamp_angle(round_q16(gain * longint'($signed(raw[i]))
                          + (65536 - gain) * longint'($signed(filter_state[i]))));
      end
    end
    filter_primed = 1'b1;
    was = recording;
    if (f.command_present) begin
      recording = f.command_record;
    end
    r.out_time = f.frame_time;
    r.joint_one = filter_state[0];
    r.joint_two = filter_state[1];
    r.joint_three = filter_state[2];
    r.joint_four = filter_state[3];
    r.joint_five = filter_state[4];
    r.joint_six = filter_state[5];
    r.record_tap = recording | was;
    r.record_done = was & ~recording;
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_cfg.lowpass_gain = LOWPASS_GAIN_RESET;
      shadow_cfg.roll_ik_weight = ROLL_IK_WEIGHT_RESET;
      shadow_cfg.roll_hand_weight = ROLL_HAND_WEIGHT_RESET;
      shadow_cfg.wrist_pitch_min = WRIST_PITCH_MIN_RESET;
      shadow_cfg.wrist_pitch_max = WRIST_PITCH_MAX_RESET;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        filter_state[i] = '0;
      end
      filter_primed = 1'b0;
      held_hand.upper_roll = '0;
      held_hand.fore_roll = '0;
      held_hand.pitch = HELD_PITCH_RESET;
      recording = 1'b0;
      expected_poses.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LOWPASS_GAIN: shadow_cfg.lowpass_gain = cfg_data;
          REG_ROLL_IK_WEIGHT: shadow_cfg.roll_ik_weight = cfg_data;
          REG_ROLL_HAND_WEIGHT: shadow_cfg.roll_hand_weight = cfg_data;
          REG_WRIST_PITCH_MIN: shadow_cfg.wrist_pitch_min = cfg_data[15:0];
          REG_WRIST_PITCH_MAX: shadow_cfg.wrist_pitch_max = cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_poses.size() == 0) begin
          $error("result transaction with no expected pose pending");
          mismatches++;
        end else begin
          want = expected_poses.pop_front();
          compare_field("out_time", longint'(want.out_time), longint'(result.out_time));
          compare_field("joint_one", longint'($signed(want.joint_one)),
                        longint'($signed(result.joint_one)));
          compare_field("joint_two", longint'($signed(want.joint_two)),
                        longint'($signed(result.joint_two)));
          compare_field("joint_three", longint'($signed(want.joint_three)),
                        longint'($signed(result.joint_three)));
          compare_field("joint_four", longint'($signed(want.joint_four)),
                        longint'($signed(result.joint_four)));
          compare_field("joint_five", longint'($signed(want.joint_five)),
                        longint'($signed(result.joint_five)));
          compare_field("joint_six", longint'($signed(want.joint_six)),
                        longint'($signed(result.joint_six)));
          compare_field("record_tap", longint'(want.record_tap), longint'(result.record_tap));
          compare_field("record_done", longint'(want.record_done),
                        longint'(result.record_done));
        end
      end
      if (frame_valid && frame_ready) begin
        expected_poses.push_back(predict_pose(frame));
      end
    end
    outstanding <= expected_poses.size();
  end

endmodule

/* test/joint_angle_fusion_lowpass_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_angle_fusion_lowpass_unit_tb: regression for the joint angle fusion
// low-pass unit. A short directed run covers angle extremes, roll negation
// and blend saturation, pitch clamping, reversed pitch limits, gains above
// one and the record flag. Random frames follow under several register
// settings, with random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module joint_angle_fusion_lowpass_unit_tb;
  import jafl_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int FRAMES_PER_PHASE = 210;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 750000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   frame_valid = 1'b0;
  logic                   frame_ready;
  frame_t                 frame = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     outstanding;
  int                     cycle_count = 0;
  bit                     hold_off_req = 1'b0;
  logic [31:0]            stamp = 32'd0;

  joint_angle_fusion_lowpass_unit uut (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame(frame),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  jafl_pose_checker checker_i (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame(frame),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  function automatic int idle_cycles(bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic angle_t rand_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 16'sh8000;
    end else if (r < 16) begin
      return 16'sh7fff;
    end else if (r < 40) begin
      return angle_t'($urandom_range(0, 4096) - 2048);
    end
    return angle_t'($urandom());
  endfunction

  function automatic angle_t rand_pitch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return angle_t'($urandom_range(0, 12800));
    end else if (r < 80) begin
      return (r < 75) ? 16'sd0 : PITCH_FULL;
    end
    return angle_t'($urandom());
  endfunction

  function automatic gain_t rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return 17'd0;
    end else if (r < 25) begin
      return 17'd65536;
    end else if (r < 35) begin
      return 17'd131071;
    end else if (r < 45) begin
      return gain_t'($urandom_range(65537, 131070));
    end
    return gain_t'($urandom_range(1, 65535));
  endfunction

  function automatic frame_t make_frame(angle_t base, angle_t shoulder, angle_t upper,
                                        angle_t elbow, logic hp, angle_t hand_upper,
                                        angle_t hand_fore, angle_t pitch, logic cp,
                                        logic cr);
    frame_t f;
    f.frame_time = $urandom();
    f.ik_base = base;
    f.ik_shoulder = shoulder;
    f.ik_upper_roll = upper;
    f.ik_elbow = elbow;
    f.hand_present = hp;
    f.hand_upper_roll = hand_upper;
    f.hand_fore_roll = hand_fore;
    f.hand_pitch = pitch;
    f.command_present = cp;
    f.command_record = cr;
    return f;
  endfunction

  function automatic frame_t random_frame();
    return make_frame(rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                      ($urandom_range(0, 99) < 45), rand_angle(), rand_angle(),
                      rand_pitch(), ($urandom_range(0, 99) < 20),
                      1'($urandom_range(0, 1)));
  endfunction

  task automatic send_frame(frame_t f, int gap);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame <= f;
    do begin
      @(posedge clk);
    end while (!frame_ready);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic settle();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    settle();
    write_reg(REG_LOWPASS_GAIN, c.lowpass_gain);
    write_reg(REG_ROLL_IK_WEIGHT, c.roll_ik_weight);
    write_reg(REG_ROLL_HAND_WEIGHT, c.roll_hand_weight);
    write_reg(REG_WRIST_PITCH_MIN, {1'b0, c.wrist_pitch_min});
    write_reg(REG_WRIST_PITCH_MAX, {1'b0, c.wrist_pitch_max});
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t pick_config(int phase);
    cfg_t c;
    case (phase)
      0: begin
        c = '{LOWPASS_GAIN_RESET, ROLL_IK_WEIGHT_RESET, ROLL_HAND_WEIGHT_RESET,
              WRIST_PITCH_MIN_RESET, WRIST_PITCH_MAX_RESET};
      end
      1: begin
        c = '{17'd1, 17'd65536, 17'd0, 16'sh8000, 16'sh7fff};
      end
      2: begin
        c = '{17'd131071, 17'd131071, 17'd131071, 16'sh7fff, 16'sh8000};
      end
      default: begin
        c.lowpass_gain = rand_gain();
        c.roll_ik_weight = rand_gain();
        c.roll_hand_weight = rand_gain();
        c.wrist_pitch_min = rand_angle();
        c.wrist_pitch_max = rand_angle();
      end
    endcase
    return c;
  endfunction

  // Result side: random ready pattern, plus one long hold-off on request.
  initial begin
    int run;
    int stall;
    int held;
    forever begin
      if (hold_off_req) begin
        result_ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_off_req = 1'b0;
      end
      result_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      stall = idle_cycles(1'b0);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("joint_angle_fusion_lowpass_unit regression: fail");
    $finish;
  end

  initial begin
    bit quiet;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Seeding frame with every angle at an extreme and the most negative fore roll.
    send_frame(make_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 16'sh8000,
                          16'sh8000, PITCH_FULL, 1'b1, 1'b1), 0);
    send_frame(make_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sh7fff, 16'sh7fff,
                          16'sd0, 1'b0, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 16'sh7fff,
                          16'sh7fff, -16'sd128, 1'b0, 1'b1), idle_cycles(1'b0));
    send_frame(make_frame(16'sd128, -16'sd128, 16'sd640, -16'sd640, 1'b1, 16'sh8000,
                          16'sd1, 16'sh7fff, 1'b0, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sd1, -16'sd1, 16'sd2, -16'sd2, 1'b0, 16'sd0, 16'sd0,
                          16'sd0, 1'b1, 1'b0), 0);
    send_frame(make_frame(16'sd3, 16'sd4, 16'sd5, 16'sd6, 1'b1, -16'sd1, -16'sd1,
                          16'sh8000, 1'b1, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sd7, 16'sd8, 16'sd9, 16'sd10, 1'b0, 16'sd0, 16'sd0,
                          16'sd0, 1'b1, 1'b1), 0);
    send_frame(make_frame(16'sd11, 16'sd12, 16'sd13, 16'sd14, 1'b1, 16'sd6400,
                          -16'sd6400, 16'sd6400, 1'b1, 1'b1), idle_cycles(1'b0));

    // Gains above one with the pitch limits reversed.
    apply_config('{17'd131071, 17'd131071, 17'd131071, 16'sh7fff, 16'sh8000});
    send_frame(make_frame(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 16'sh7fff,
                          16'sh8000, 16'sd0, 1'b0, 1'b0), 0);
    send_frame(make_frame(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000,
                          16'sh7fff, PITCH_FULL, 1'b0, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 16'sd0,
                          16'sd0, 16'sd0, 1'b1, 1'b0), 0);
    send_frame(make_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0,
                          16'sd6400, 1'b0, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 16'sh8000,
                          16'sh8000, -16'sd1, 1'b0, 1'b0), 0);

    // Zero gain and zero weights, widest pitch limits; the unused index is ignored.
    apply_config('{17'd0, 17'd0, 17'd0, 16'sh8000, 16'sh7fff});
    @(posedge clk);
    write_reg(REG_UNUSED, 17'h1ffff);
    cfg_write <= 1'b0;
    send_frame(make_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 16'sh7fff,
                          16'sh7fff, PITCH_FULL, 1'b0, 1'b0), 0);
    send_frame(make_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 16'sh8000,
                          16'sh8000, 16'sd1, 1'b1, 1'b1), idle_cycles(1'b0));
    send_frame(make_frame(16'sd100, 16'sd200, 16'sd300, 16'sd400, 1'b0, 16'sd0, 16'sd0,
                          16'sd0, 1'b0, 1'b0), 0);

    // Unity gain passes the raw angles straight through.
    apply_config('{17'd65536, 17'd65536, 17'd65536, -16'sd100, 16'sd100});
    send_frame(make_frame(16'sh7fff, 16'sh8000, 16'sh4000, -16'sd5, 1'b1, 16'sh7fff,
                          16'sh8000, 16'sd3200, 1'b0, 1'b0), 0);
    send_frame(make_frame(-16'sd7, 16'sd9, 16'sh8000, 16'sh7fff, 1'b1, 16'sh8000,
                          16'sd5, 16'sd9600, 1'b1, 1'b0), idle_cycles(1'b0));
    send_frame(make_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0,
                          1'b0, 1'b0), 0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_config(pick_config(phase));
      if (phase == 1) begin
        hold_off_req = 1'b1;
      end
      quiet = 1'b0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (n % 30 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        send_frame(random_frame(), idle_cycles(quiet));
      end
    end

    frame_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("joint_angle_fusion_lowpass_unit regression: pass");
    end else begin
      $display("joint_angle_fusion_lowpass_unit regression: fail");
    end
    $finish;
  end

endmodule
